// File: design/ltt_pkg.sv
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and constants for the two-view triangulation block
// Operand map of the solver scratch store, configuration register indexes,
// camera reset values and the micro-op table of the solve sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ltt_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_CAM1_ROW0 = 3'd0;
	localparam logic [2:0] CFG_CAM1_ROW1 = 3'd1;
	localparam logic [2:0] CFG_CAM1_ROW2 = 3'd2;
	localparam logic [2:0] CFG_CAM2_ROW0 = 3'd3;
	localparam logic [2:0] CFG_CAM2_ROW1 = 3'd4;
	localparam logic [2:0] CFG_CAM2_ROW2 = 3'd5;

	// camera rows after reset: [I | 0] in Q4.12
	localparam logic [63:0] CAM_ROW0_RST = 64'h0000_0000_0000_1000;
	localparam logic [63:0] CAM_ROW1_RST = 64'h0000_0000_1000_0000;
	localparam logic [63:0] CAM_ROW2_RST = 64'h0000_1000_0000_0000;

	// operand addresses: A rows and B live in the queue, the rest in scratch
	localparam int QUEUE_VALS = 16;
	localparam logic [5:0] B_BASE  = 6'd12;
	localparam logic [5:0] RF_BASE = 6'd16;
	localparam int RF_DEPTH = 19;
	localparam int RF_IDX_W = 5;
	localparam logic [5:0] N00   = 6'd16;
	localparam logic [5:0] N01   = 6'd17;
	localparam logic [5:0] N02   = 6'd18;
	localparam logic [5:0] N11   = 6'd19;
	localparam logic [5:0] N12   = 6'd20;
	localparam logic [5:0] N22   = 6'd21;
	localparam logic [5:0] C0    = 6'd22;
	localparam logic [5:0] C1    = 6'd23;
	localparam logic [5:0] C2    = 6'd24;
	localparam logic [5:0] ADJ00 = 6'd25;
	localparam logic [5:0] ADJ01 = 6'd26;
	localparam logic [5:0] ADJ02 = 6'd27;
	localparam logic [5:0] ADJ11 = 6'd28;
	localparam logic [5:0] ADJ12 = 6'd29;
	localparam logic [5:0] ADJ22 = 6'd30;
	localparam logic [5:0] DET_A = 6'd31;
	localparam logic [5:0] NUM0  = 6'd32;

	localparam logic [5:0] LAST_UOP = 6'd59;
	localparam int DIV_BITS = 33;
	localparam logic [1:0] LAST_K = 2'd2;
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	// one multiply-accumulate step: acc = (clr ? 0 : acc) +/- x * y
	typedef struct packed {
		logic [5:0] xa;
		logic [5:0] ya;
		logic       ylong;  // y spans the normal-matrix width
		logic       neg;
		logic       clr;
		logic       wr;
		logic [5:0] dst;
	} uop_t;

	function automatic uop_t mk_uop(input logic [5:0] xa, input logic [5:0] ya,
			input logic neg, input logic clr, input logic wr, input logic [5:0] dst);
		uop_t u;
		u.xa = xa;
		u.ya = ya;
		u.ylong = 1'b1;
		u.neg = neg;
		u.clr = clr;
		u.wr = wr;
		u.dst = dst;
		return u;
	endfunction

	// sequencer program: normal matrix, right side, adjugate, det, numerators
	function automatic uop_t uop_rom(input logic [5:0] pc);
		uop_t u;
		logic [5:0] j;
		logic [1:0] r;
		logic [2:0] e;
		logic [1:0] p;
		logic [1:0] q;
		u = '0;
		j = pc - 6'd24;
		r = pc[1:0];
		e = {1'b0, pc[4:3]} + {2'b00, pc[2]};
		p = 2'd0;
		q = 2'd0;
		if (pc < 6'd24) begin
			// N(p,q) = sum over rows of A(r,p) * A(r,q)
			e = pc[4:2];
			unique case (e)
				3'd0: begin p = 2'd0; q = 2'd0; end
				3'd1: begin p = 2'd0; q = 2'd1; end
				3'd2: begin p = 2'd0; q = 2'd2; end
				3'd3: begin p = 2'd1; q = 2'd1; end
				3'd4: begin p = 2'd1; q = 2'd2; end
				3'd5: begin p = 2'd2; q = 2'd2; end
				default: begin p = 2'd0; q = 2'd0; end
			endcase
			u.xa = 6'({4'd0, r}) * 6'd3 + 6'({4'd0, p});
			u.ya = 6'({4'd0, r}) * 6'd3 + 6'({4'd0, q});
			u.clr = (r == 2'd0);
			u.wr = (r == 2'd3);
			u.dst = N00 + 6'({3'd0, e});
		end else if (pc < 6'd36) begin
			// c(p) = sum over rows of A(r,p) * B(r)
			r = j[1:0];
			p = j[3:2];
			u.xa = 6'({4'd0, r}) * 6'd3 + 6'({4'd0, p});
			u.ya = B_BASE + 6'({4'd0, r});
			u.clr = (r == 2'd0);
			u.wr = (r == 2'd3);
			u.dst = C0 + 6'({4'd0, p});
		end else begin
			unique case (pc)
				6'd36: u = mk_uop(N11, N22, 1'b0, 1'b1, 1'b0, ADJ00);
				6'd37: u = mk_uop(N12, N12, 1'b1, 1'b0, 1'b1, ADJ00);
				6'd38: u = mk_uop(N02, N12, 1'b0, 1'b1, 1'b0, ADJ01);
				6'd39: u = mk_uop(N01, N22, 1'b1, 1'b0, 1'b1, ADJ01);
				6'd40: u = mk_uop(N01, N12, 1'b0, 1'b1, 1'b0, ADJ02);
				6'd41: u = mk_uop(N02, N11, 1'b1, 1'b0, 1'b1, ADJ02);
				6'd42: u = mk_uop(N00, N22, 1'b0, 1'b1, 1'b0, ADJ11);
				6'd43: u = mk_uop(N02, N02, 1'b1, 1'b0, 1'b1, ADJ11);
				6'd44: u = mk_uop(N01, N02, 1'b0, 1'b1, 1'b0, ADJ12);
				6'd45: u = mk_uop(N00, N12, 1'b1, 1'b0, 1'b1, ADJ12);
				6'd46: u = mk_uop(N00, N11, 1'b0, 1'b1, 1'b0, ADJ22);
				6'd47: u = mk_uop(N01, N01, 1'b1, 1'b0, 1'b1, ADJ22);
				6'd48: u = mk_uop(ADJ00, N00, 1'b0, 1'b1, 1'b0, DET_A);
				6'd49: u = mk_uop(ADJ01, N01, 1'b0, 1'b0, 1'b0, DET_A);
				6'd50: u = mk_uop(ADJ02, N02, 1'b0, 1'b0, 1'b1, DET_A);
				6'd51: u = mk_uop(ADJ00, C0, 1'b0, 1'b1, 1'b0, NUM0);
				6'd52: u = mk_uop(ADJ01, C1, 1'b0, 1'b0, 1'b0, NUM0);
				6'd53: u = mk_uop(ADJ02, C2, 1'b0, 1'b0, 1'b1, NUM0);
				6'd54: u = mk_uop(ADJ01, C0, 1'b0, 1'b1, 1'b0, NUM0 + 6'd1);
				6'd55: u = mk_uop(ADJ11, C1, 1'b0, 1'b0, 1'b0, NUM0 + 6'd1);
				6'd56: u = mk_uop(ADJ12, C2, 1'b0, 1'b0, 1'b1, NUM0 + 6'd1);
				6'd57: u = mk_uop(ADJ02, C0, 1'b0, 1'b1, 1'b0, NUM0 + 6'd2);
				6'd58: u = mk_uop(ADJ12, C1, 1'b0, 1'b0, 1'b0, NUM0 + 6'd2);
				6'd59: u = mk_uop(ADJ22, C2, 1'b0, 1'b0, 1'b1, NUM0 + 6'd2);
				default: u = mk_uop(ADJ22, C2, 1'b0, 1'b0, 1'b0, NUM0 + 6'd2);
			endcase
		end
		return u;
	endfunction

endpackage

`default_nettype wire

// File: design/linear_two_view_triangulation.sv
// ----------------------------------------------------------------------------
// linear_two_view_triangulation: least-squares 3D point from two views
// Channel     | dir | handshake                     | payload
// s_axis      | in  | s_axis_tvalid/s_axis_tready   | tdata: view1_x, view1_y, view2_x, view2_y
// m_axis      | out | m_axis_tvalid/m_axis_tready   | tdata: point_x, point_y, point_z; tuser: singular
// cfg         | in  | cfg_we                        | cfg_index, cfg_data (camera rows)
//
// The solver works on one point at a time; its operands are AW = COORD_WIDTH+17
// bits wide for A and B and NW = 2*AW+1 bits for the normal matrix, and its pace
// is set by the single shared bit-serial multiply-accumulate of the solver.
// Setup is registered; its register and the two queue slots hold up to three
// points, the queue head being the one the solver works on.
// Reset loads both cameras with [I | 0]; the scratch store needs no clearing.
// A stalled output holds in its register; the solver works on the next point meanwhile but waits to hand it on.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_two_view_triangulation #(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// view1_x, view1_y, view2_x, view2_y (COORD_WIDTH each), zero pad to bytes
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// point_x [31:0], point_y [63:32], point_z [95:64]
	output logic [95:0] m_axis_tdata,
	// singular [0]
	output logic [0:0] m_axis_tuser
);

	localparam int AW = COORD_WIDTH + 17;

	logic ab_valid;
	logic ab_ready;
	logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] ab_data;
	logic q_valid;
	logic q_pop;
	logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] q_data;
	logic [31:0] px;
	logic [31:0] py;
	logic [31:0] pz;
	logic sing;

	ltt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata[4*COORD_WIDTH-1:0]),
		.ab_valid (ab_valid),
		.ab_ready (ab_ready),
		.ab_data  (ab_data)
	);

	ltt_queue #(.COORD_WIDTH(COORD_WIDTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ab_valid),
		.in_ready (ab_ready),
		.in_data  (ab_data),
		.out_valid(q_valid),
		.out_pop  (q_pop),
		.out_data (q_data)
	);

	ltt_solve #(.COORD_WIDTH(COORD_WIDTH)) u_solve (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_data      (q_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_x       (px),
		.out_y       (py),
		.out_z       (pz),
		.out_singular(sing)
	);

	assign m_axis_tdata = {pz, py, px};
	assign m_axis_tuser = sing;

endmodule

`default_nettype wire

// File: design/ltt_front.sv
// ----------------------------------------------------------------------------
// ltt_front: camera registers and linear system setup
// Holds the two camera matrices, registers each accepted point and forms
// the four rows of A and the entries of B (Q.24) for the solver queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ltt_front #(
	parameter int COORD_WIDTH = 16,
	localparam int AW = COORD_WIDTH + 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [63:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [4*COORD_WIDTH-1:0] in_data,
	output logic                     ab_valid,
	input  logic                     ab_ready,
	output logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] ab_data
);

	logic [63:0] cam_q [6];
	logic [3:0][COORD_WIDTH-1:0] coord_s1;
	logic v_s1;

	// camera register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= ltt_pkg::CAM_ROW0_RST;
			cam_q[1] <= ltt_pkg::CAM_ROW1_RST;
			cam_q[2] <= ltt_pkg::CAM_ROW2_RST;
			cam_q[3] <= ltt_pkg::CAM_ROW0_RST;
			cam_q[4] <= ltt_pkg::CAM_ROW1_RST;
			cam_q[5] <= ltt_pkg::CAM_ROW2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ltt_pkg::CFG_CAM1_ROW0: cam_q[0] <= cfg_data;
				ltt_pkg::CFG_CAM1_ROW1: cam_q[1] <= cfg_data;
				ltt_pkg::CFG_CAM1_ROW2: cam_q[2] <= cfg_data;
				ltt_pkg::CFG_CAM2_ROW0: cam_q[3] <= cfg_data;
				ltt_pkg::CFG_CAM2_ROW1: cam_q[4] <= cfg_data;
				ltt_pkg::CFG_CAM2_ROW2: cam_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	assign in_ready = !v_s1 || ab_ready;
	assign ab_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			coord_s1 <= in_data;
		end
	end

	// A(r,j) = u * P(2,j) - P(sel,j) * 4096, B(r) = -(u * P(2,3) - P(sel,3) * 4096)
	for (genvar r = 0; r < 4; r++) begin : g_row
		localparam int V = r / 2;
		localparam int SEL = r % 2;
		logic signed [COORD_WIDTH-1:0] u;
		assign u = coord_s1[r];
		for (genvar j = 0; j < 4; j++) begin : g_col
			logic signed [15:0] e2;
			logic signed [15:0] es;
			logic signed [COORD_WIDTH+15:0] prod;
			logic signed [AW-1:0] term;
			assign e2 = cam_q[V*3+2][16*j +: 16];
			assign es = cam_q[V*3+SEL][16*j +: 16];
			assign prod = u * e2;
			// entry scaled to Q.24
			assign term = AW'(prod) - AW'(signed'({es, 12'b0}));
			if (j < 3) begin : g_a
				assign ab_data[r*3+j] = term;
			end else begin : g_b
				assign ab_data[int'(ltt_pkg::B_BASE)+r] = -term;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/ltt_queue.sv
// ----------------------------------------------------------------------------
// ltt_queue: two-entry request queue between setup and solver
// Slot 0 is always the head, so the solver reads it at a fixed place.
// ----------------------------------------------------------------------------
`default_nettype none

module ltt_queue #(
	parameter int COORD_WIDTH = 16,
	localparam int AW = COORD_WIDTH + 17
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] in_data,
	output logic out_valid,
	input  logic out_pop,
	output logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] out_data
);

	logic [1:0] cnt_q;
	logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] slot0_q;
	logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] slot1_q;
	logic push;
	logic pop;
	logic to_head;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = slot0_q;
	assign push = in_valid && in_ready;
	assign pop = out_pop && out_valid;
	// a new request lands at the head when the queue is, or is becoming, empty
	assign to_head = (cnt_q == 2'd0) || (pop && cnt_q == 2'd1);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// slot moves
	always_ff @(posedge clk) begin
		if (push && to_head) begin
			slot0_q <= in_data;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
		if (push && !to_head) begin
			slot1_q <= in_data;
		end
	end

endmodule

`default_nettype wire

// File: design/ltt_solve.sv
// ----------------------------------------------------------------------------
// ltt_solve: normal-equation solver
// A micro-op sequencer drives one bit-serial signed multiply-accumulate over
// a scratch store to form A^T A, A^T B, the adjugate, the determinant and
// the three numerators; a restoring divider then gives each Q16.16 output.
// ----------------------------------------------------------------------------
`default_nettype none

module ltt_solve #(
	parameter int COORD_WIDTH = 16,
	localparam int AW = COORD_WIDTH + 17
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  logic [ltt_pkg::QUEUE_VALS-1:0][AW-1:0] q_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic out_singular
);

	localparam int NW = 2 * AW + 1;   // normal matrix and right side
	localparam int RW = 3 * NW + 2;   // determinant and numerators
	localparam int MW = RW + 18;      // scaled dividend
	localparam int CW = $clog2(NW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_RDX, S_RDY, S_LDY, S_MUL, S_WB, S_DET, S_DLD,
		S_NRD, S_DINIT, S_DPREP, S_DCHK, S_DIV, S_DFIN, S_OUT
	} state_t;

	state_t state_q;
	logic [5:0] pc_q;
	logic [1:0] k_q;
	ltt_pkg::uop_t uop;

	logic [RW-1:0] rf_mem [ltt_pkg::RF_DEPTH];
	logic [RW-1:0] rd_q;
	logic [5:0] raddr;
	logic rd_en;
	logic [ltt_pkg::RF_IDX_W-1:0] rd_idx;
	logic [ltt_pkg::RF_IDX_W-1:0] wr_idx;
	logic rf_we;

	logic [5:0] op_addr;
	logic [AW-1:0] qword;
	logic [RW-1:0] opnd;

	logic [RW-1:0] mcand_q;
	logic [NW-1:0] mplier_q;
	logic [RW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic sub;
	logic [RW-1:0] addend;

	logic [RW-1:0] dabs_q;
	logic dsign_q;
	logic [RW-1:0] nabs_q;
	logic nsign_q;
	logic [MW-1:0] mn_q;
	logic [RW:0] rem_q;
	logic [ltt_pkg::DIV_BITS-1:0] dvd_q;
	logic [ltt_pkg::DIV_BITS-1:0] quo_q;
	logic big_q;
	logic [RW+2:0] trial;
	logic [31:0] sat;
	logic [31:0] res_q [3];
	logic singular_q;

	logic out_valid_q;
	logic out_take;

	assign uop = ltt_pkg::uop_rom(pc_q);
	assign q_pop = (state_q == S_WB) && (pc_q == ltt_pkg::LAST_UOP);
	assign out_take = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// scratch read address
	always_comb begin
		unique case (state_q)
			S_RDX:   raddr = uop.xa;
			S_RDY:   raddr = uop.ya;
			S_DET:   raddr = ltt_pkg::DET_A;
			S_NRD:   raddr = ltt_pkg::NUM0 + {4'd0, k_q};
			default: raddr = uop.xa;
		endcase
	end

	assign rd_en = (raddr >= ltt_pkg::RF_BASE);
	assign rd_idx = ltt_pkg::RF_IDX_W'(raddr - ltt_pkg::RF_BASE);
	assign wr_idx = ltt_pkg::RF_IDX_W'(uop.dst - ltt_pkg::RF_BASE);
	assign rf_we = (state_q == S_WB) && uop.wr;

	// scratch store
	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[wr_idx] <= acc_q;
		end
		if (rd_en) begin
			rd_q <= rf_mem[rd_idx];
		end
	end

	// operand select: A and B from the queue head, the rest from scratch
	assign op_addr = (state_q == S_RDY) ? uop.xa : uop.ya;
	assign qword = q_data[op_addr[3:0]];
	assign opnd = (op_addr < ltt_pkg::RF_BASE) ? {{(RW-AW){qword[AW-1]}}, qword} : rd_q;

	// multiply step: the top multiplier bit carries negative weight
	assign sub = uop.neg ^ (cnt_q == CW'(1));
	assign addend = mcand_q ^ {RW{sub}};

	// divide step
	assign trial = {1'b0, rem_q, dvd_q[ltt_pkg::DIV_BITS-1]} - {2'b00, dabs_q, 1'b0};

	// saturation of the rounded quotient
	always_comb begin
		if (nsign_q ^ dsign_q) begin
			if (big_q || quo_q > 33'h0_8000_0000) begin
				sat = ltt_pkg::SAT_NEG;
			end else begin
				sat = ~quo_q[31:0] + 32'd1;
			end
		end else begin
			if (big_q || quo_q > 33'h0_7FFF_FFFF) begin
				sat = ltt_pkg::SAT_POS;
			end else begin
				sat = quo_q[31:0];
			end
		end
	end

	// sequencer and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						pc_q <= '0;
						state_q <= S_RDX;
					end
				end
				S_RDX: state_q <= S_RDY;
				S_RDY: state_q <= S_LDY;
				S_LDY: state_q <= S_MUL;
				S_MUL: begin
					if (cnt_q == CW'(1)) state_q <= S_WB;
				end
				S_WB: begin
					if (pc_q == ltt_pkg::LAST_UOP) begin
						state_q <= S_DET;
					end else begin
						pc_q <= pc_q + 6'd1;
						state_q <= S_RDX;
					end
				end
				S_DET: state_q <= S_DLD;
				S_DLD: begin
					if (rd_q == '0) begin
						state_q <= S_OUT;
					end else begin
						k_q <= '0;
						state_q <= S_NRD;
					end
				end
				S_NRD:   state_q <= S_DINIT;
				S_DINIT: state_q <= S_DPREP;
				S_DPREP: state_q <= S_DCHK;
				S_DCHK:  state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == CW'(1)) state_q <= S_DFIN;
				end
				S_DFIN: begin
					if (k_q == ltt_pkg::LAST_K) begin
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_NRD;
					end
				end
				S_OUT: begin
					if (out_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_RDY: mcand_q <= opnd;
			S_LDY: begin
				mplier_q <= NW'(opnd);
				cnt_q <= uop.ylong ? CW'(NW) : CW'(AW);
				if (uop.clr) acc_q <= '0;
			end
			S_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + addend + RW'(sub);
				mcand_q <= {mcand_q[RW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[NW-1:1]};
				cnt_q <= cnt_q - CW'(1);
			end
			S_DLD: begin
				dsign_q <= rd_q[RW-1];
				dabs_q <= rd_q[RW-1] ? (~rd_q + RW'(1)) : rd_q;
				singular_q <= (rd_q == '0);
				if (rd_q == '0) begin
					res_q[0] <= '0;
					res_q[1] <= '0;
					res_q[2] <= '0;
				end
			end
			S_DINIT: begin
				nsign_q <= rd_q[RW-1];
				nabs_q <= rd_q[RW-1] ? (~rd_q + RW'(1)) : rd_q;
			end
			// |num| * 2^17 + |det|, over 2|det|: rounds to nearest, ties away
			S_DPREP: mn_q <= MW'({nabs_q, 17'b0}) + MW'(dabs_q);
			S_DCHK: begin
				big_q <= MW'(mn_q[MW-1:ltt_pkg::DIV_BITS]) >= MW'({dabs_q, 1'b0});
				rem_q <= (RW+1)'(mn_q[MW-1:ltt_pkg::DIV_BITS]);
				dvd_q <= mn_q[ltt_pkg::DIV_BITS-1:0];
				quo_q <= '0;
				cnt_q <= CW'(ltt_pkg::DIV_BITS);
			end
			S_DIV: begin
				if (!trial[RW+2]) begin
					rem_q <= trial[RW:0];
				end else begin
					rem_q <= {rem_q[RW-1:0], dvd_q[ltt_pkg::DIV_BITS-1]};
				end
				quo_q <= {quo_q[ltt_pkg::DIV_BITS-2:0], !trial[RW+2]};
				dvd_q <= {dvd_q[ltt_pkg::DIV_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			S_DFIN: res_q[k_q] <= sat;
			default: ;
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_take) begin
			out_x <= res_q[0];
			out_y <= res_q[1];
			out_z <= res_q[2];
			out_singular <= singular_q;
		end
	end

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("solver popped an empty queue");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_singular) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("singular result carries a nonzero point");

	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV) |-> (cnt_q != '0))
		else $error("serial step counter ran out");

	a_wb_target: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (uop.dst >= ltt_pkg::RF_BASE))
		else $error("write back aimed at a queue operand");

endmodule

`default_nettype wire
